// ----- hw/rtl/hssp_pkg.sv -----
// Package with types, constants and the coil table of the half-step stepper positioner.
`timescale 1ns / 1ps
package hssp_pkg;

	localparam int PHASES_PER_STEP = 8;
	localparam int PHASE_W         = $clog2(PHASES_PER_STEP);
	localparam int HOLD_W          = 16;
	localparam int LIMIT_W         = 8;
	localparam int POS_W           = 9;
	localparam int TARGET_W        = 10;
	localparam int COIL_W          = 4;
	localparam int IN_DATA_W       = 16;
	localparam int OUT_DATA_W      = 24;
	localparam int CFG_INDEX_W     = 1;
	localparam int CFG_DATA_W      = 16;

	localparam logic [HOLD_W-1:0]  TICKS_RESET = HOLD_W'(1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);
	localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(255);
	localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(255);

	typedef enum logic {
		ACT_TICK   = 1'b0,
		ACT_TARGET = 1'b1
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TICKS_PER_PHASE = 1'b0,
		REG_POSITION_LIMIT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		action_t                     action;
		logic signed [TARGET_W-1:0]  target;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] held_target;
		logic                    busy_res;
		logic signed [POS_W-1:0] position;
		logic [COIL_W-1:0]       coils;
	} result_t;

	function automatic logic [COIL_W-1:0] coil_entry(input logic [PHASE_W-1:0] idx);
		logic [COIL_W-1:0] c;
		case (idx)
			3'd0:    c = 4'h1;
			3'd1:    c = 4'h3;
			3'd2:    c = 4'h2;
			3'd3:    c = 4'h6;
			3'd4:    c = 4'h4;
			3'd5:    c = 4'hC;
			3'd6:    c = 4'h8;
			3'd7:    c = 4'h9;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/hssp_core.sv -----
// Motion state and per-item update logic of the stepper positioner.
`timescale 1ns / 1ps
module hssp_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  hssp_pkg::item_t                item,
	input  logic [hssp_pkg::HOLD_W-1:0]    ticks_per_phase,
	input  logic [hssp_pkg::LIMIT_W-1:0]   position_limit,
	output hssp_pkg::result_t              result
);
	import hssp_pkg::*;

	logic signed [POS_W-1:0] cur_q, goal_q, cur_d, goal_d;
	logic [PHASE_W-1:0]      phase_q, phase_d;
	logic [HOLD_W-1:0]       hold_cnt_q, hold_cnt_d;
	logic                    step_q, step_d, dir_q, dir_d;
	logic [COIL_W-1:0]       coil_q, coil_d;

	logic signed [TARGET_W:0] t_ext, lim_ext, t_clamp;
	logic [HOLD_W-1:0]        hold, hc_inc;
	logic                     tick;

	assign tick    = en && (item.action == ACT_TICK);
	assign t_ext   = {item.target[TARGET_W-1], item.target};
	assign lim_ext = {{(TARGET_W+1-LIMIT_W){1'b0}}, position_limit};
	assign hold    = (ticks_per_phase == '0) ? HOLD_W'(1) : ticks_per_phase;

	always_comb begin
		t_clamp = t_ext;
		if (t_ext > lim_ext) begin
			t_clamp = lim_ext;
		end
		if (t_ext < -lim_ext) begin
			t_clamp = -lim_ext;
		end
	end

	always_comb begin
		cur_d      = cur_q;
		goal_d     = goal_q;
		phase_d    = phase_q;
		hold_cnt_d = hold_cnt_q;
		step_d     = step_q;
		dir_d      = dir_q;
		coil_d     = coil_q;
		hc_inc     = '0;
		if (en && item.action == ACT_TARGET) begin
			goal_d = t_clamp[POS_W-1:0];
		end else if (tick) begin
			if (!step_q && cur_q != goal_q) begin
				step_d     = 1'b1;
				dir_d      = goal_q > cur_q;
				phase_d    = '0;
				hold_cnt_d = '0;
			end
			if (step_d) begin
				coil_d = coil_entry(dir_d ? ~phase_d : phase_d);
				hc_inc = hold_cnt_d + HOLD_W'(1);
				hold_cnt_d = hc_inc;
				if (hc_inc >= hold || hc_inc == '0) begin
					hold_cnt_d = '0;
					if (phase_d == PHASE_W'(PHASES_PER_STEP - 1)) begin
						step_d  = 1'b0;
						phase_d = '0;
						if (dir_d) begin
							if (cur_q < POS_MAX) begin
								cur_d = cur_q + POS_W'(1);
							end
						end else begin
							if (cur_q > POS_MIN) begin
								cur_d = cur_q - POS_W'(1);
							end
						end
					end else begin
						phase_d = phase_d + PHASE_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			goal_q     <= '0;
			phase_q    <= '0;
			hold_cnt_q <= '0;
			step_q     <= 1'b0;
			dir_q      <= 1'b0;
			coil_q     <= '0;
		end else begin
			cur_q      <= cur_d;
			goal_q     <= goal_d;
			phase_q    <= phase_d;
			hold_cnt_q <= hold_cnt_d;
			step_q     <= step_d;
			dir_q      <= dir_d;
			coil_q     <= coil_d;
		end
	end

	assign result.coils       = coil_d;
	assign result.position    = cur_d;
	assign result.busy_res    = step_d || (cur_d != goal_d);
	assign result.held_target = goal_d;

	a_pos_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(cur_q))
		else $error("position moved without a tick");

	a_phase_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != '0) |-> step_q)
		else $error("phase index advanced outside a step");

	a_dir_held: assert property (@(posedge clk) disable iff (!arst_n)
		step_q |=> (!step_q || $stable(dir_q)))
		else $error("direction changed during a step");

	a_goal_range: assert property (@(posedge clk) disable iff (!arst_n)
		goal_q != {1'b1, {(POS_W-1){1'b0}}})
		else $error("held target out of range");

endmodule

// ----- hw/rtl/half_step_stepper_positioner.sv -----
// Top level of the half-step stepper positioner: input stage, result register, config.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tdata: target; tuser: action
//  m_*     | out | m_tvalid/m_tready  | tdata: coils, position, busy_res, held_target
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle while m_tready keeps up; an accepted word passes the input stage, then the result register.
// The input stage and the result register each hold one word, so a word is
// accepted while the previous result waits. Stalls on m_tready back up to
// s_tready only once both are full. The config channel is always ready.
// Reset clears motion state, config to its defaults, and all valid flags.
`timescale 1ns / 1ps
module half_step_stepper_positioner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hssp_pkg::IN_DATA_W-1:0]    s_tdata,   // target[9:0], zero pad
	input  logic                              s_tuser,   // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hssp_pkg::OUT_DATA_W-1:0]   m_tdata,   // coils, position, busy_res, held_target, pad
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hssp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hssp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hssp_pkg::*;

	item_t               item_s1;
	logic                vld_s1;
	logic                adv;
	result_t             res_d, res_q;
	logic                out_vld_q;
	logic [HOLD_W-1:0]   ticks_q;
	logic [LIMIT_W-1:0]  limit_q;

	assign adv       = !out_vld_q || m_tready;
	assign s_tready  = !vld_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action <= action_t'(s_tuser);
			item_s1.target <= s_tdata[TARGET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TICKS_PER_PHASE: ticks_q <= cfg_data[HOLD_W-1:0];
				REG_POSITION_LIMIT:  limit_q <= cfg_data[LIMIT_W-1:0];
				default:             ticks_q <= ticks_q;
			endcase
		end
	end

	hssp_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (vld_s1 && adv),
		.item            (item_s1),
		.ticks_per_phase (ticks_q),
		.position_limit  (limit_q),
		.result          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_q};

endmodule
